FILE: design/assert_macros.svh
// assert_macros.svh: assertion shorthands for the frame checker.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fcc_pkg.sv
// fcc_pkg: shared types, constants and the CRC-16/MODBUS byte update
// for the CRC-16 frame checker. No dependencies.
package fcc_pkg;

    localparam int CNT_W       = 17;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0] CNT_MAX         = 17'h1FFFF;
    localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY        = 16'hA001;
    localparam logic [15:0]      MAX_PAYLOAD_RST = 16'd256;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 8'd3;

    // Fixed frame positions
    localparam logic [CNT_W-1:0] POS_SYNC0   = 17'd0;
    localparam logic [CNT_W-1:0] POS_SYNC1   = 17'd1;
    localparam logic [CNT_W-1:0] POS_VERSION = 17'd2;
    localparam logic [CNT_W-1:0] POS_TYPE    = 17'd3;
    localparam logic [CNT_W-1:0] POS_LEN_LO  = 17'd4;
    localparam logic [CNT_W-1:0] POS_LEN_HI  = 17'd5;
    localparam logic [CNT_W-1:0] POS_PAYLOAD = 17'd6;
    localparam logic [CNT_W:0]   MIN_FRAME   = 18'd8;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_BAD_SYNC,
        ST_BAD_VERSION,
        ST_BAD_LENGTH,
        ST_BAD_CRC
    } fcc_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fcc_in_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        fcc_status_t status;
        logic [7:0]  frame_type;
        logic [15:0] frame_len;
    } fcc_out_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  version_value;
        logic [15:0] max_payload;
    } fcc_cfg_t;

    // One byte of reflected CRC-16, eight shift steps unrolled.
    function automatic logic [15:0] fcc_crc_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: design/fcc_cfg_regs.sv
// fcc_cfg_regs: configuration register file of the frame checker.
// Depends on fcc_pkg.
module fcc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fcc_pkg::fcc_cfg_t              cfg
);
    import fcc_pkg::*;

    fcc_cfg_t cfg_reg;
    fcc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first    = cfg_data[7:0];
                CFG_SYNC_SECOND: cfg_next.sync_second   = cfg_data[7:0];
                CFG_VERSION:     cfg_next.version_value = cfg_data[7:0];
                CFG_MAX_PAYLOAD: cfg_next.max_payload   = cfg_data[15:0];
                default:         cfg_next = cfg_reg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= 8'h00;
            cfg_reg.sync_second   <= 8'h00;
            cfg_reg.version_value <= 8'h00;
            cfg_reg.max_payload   <= MAX_PAYLOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/fcc_frame.sv
// fcc_frame: per-frame state (position, CRC, delay line, header fields)
// and the result logic for one byte. Depends on fcc_pkg.
module fcc_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  fcc_pkg::fcc_in_t  item,
    input  fcc_pkg::fcc_cfg_t cfg,
    output fcc_pkg::fcc_out_t result
);
    import fcc_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       type_reg, type_next;
    logic             sync_ok_reg, sync_ok_next;
    logic             ver_ok_reg, ver_ok_next;

    // values after this byte's header capture
    logic [CNT_W-1:0] p;
    logic [7:0]       b;
    logic             sync_ok_upd, ver_ok_upd;
    logic [7:0]       type_upd;
    logic [15:0]      len_upd;
    logic [15:0]      crc_upd;
    logic [CNT_W-1:0] count_upd;
    logic [CNT_W:0]   total;
    logic [15:0]      rx_crc;
    logic             pv;
    fcc_status_t      st;

    assign p = count_reg;
    assign b = item.data_byte;

    always_comb
    begin
        sync_ok_upd = sync_ok_reg;
        if ((p == POS_SYNC0 && b != cfg.sync_first) ||
            (p == POS_SYNC1 && b != cfg.sync_second))
        begin
            sync_ok_upd = 1'b0;
        end
        ver_ok_upd = (p == POS_VERSION) ? (b == cfg.version_value) : ver_ok_reg;
        type_upd   = (p == POS_TYPE) ? b : type_reg;
        len_upd    = len_reg;
        if (p == POS_LEN_LO)
        begin
            len_upd = {len_reg[15:8], b};
        end
        if (p == POS_LEN_HI)
        begin
            len_upd = {b, len_reg[7:0]};
        end

        pv = (p >= POS_PAYLOAD) && ((p - POS_PAYLOAD) < {1'b0, len_upd});

        // the two newest bytes stay out of the CRC until they age out
        crc_upd   = (p >= POS_LEN_LO) ? fcc_crc_byte(crc_reg, held1_reg) : crc_reg;
        count_upd = (p == CNT_MAX) ? p : p + 1'b1;

        total  = {1'b0, p} + 1'b1;
        rx_crc = {b, held0_reg};

        if (total < MIN_FRAME)
            st = ST_SHORT;
        else if (!sync_ok_upd)
            st = ST_BAD_SYNC;
        else if (!ver_ok_upd)
            st = ST_BAD_VERSION;
        else if (len_upd > cfg.max_payload ||
                 total != MIN_FRAME + {2'b00, len_upd})
            st = ST_BAD_LENGTH;
        else if (rx_crc != crc_upd)
            st = ST_BAD_CRC;
        else
            st = ST_OK;

        result.payload_byte  = b;
        result.payload_valid = pv;
        result.frame_done    = item.last_byte;
        result.status        = item.last_byte ? st : ST_OK;
        result.frame_type    = (item.last_byte && st == ST_OK) ? type_upd : 8'h00;
        result.frame_len     = (item.last_byte && st == ST_OK) ? len_upd : 16'h0000;
    end

    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        sync_ok_next = sync_ok_reg;
        ver_ok_next  = ver_ok_reg;
        if (fire)
        begin
            if (item.last_byte)
            begin
                count_next   = '0;
                crc_next     = CRC_INIT;
                held0_next   = 8'h00;
                held1_next   = 8'h00;
                len_next     = 16'h0000;
                type_next    = 8'h00;
                sync_ok_next = 1'b1;
                ver_ok_next  = 1'b1;
            end
            else
            begin
                count_next   = count_upd;
                crc_next     = crc_upd;
                held0_next   = b;
                held1_next   = held0_reg;
                len_next     = len_upd;
                type_next    = type_upd;
                sync_ok_next = sync_ok_upd;
                ver_ok_next  = ver_ok_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            held0_reg   <= 8'h00;
            held1_reg   <= 8'h00;
            len_reg     <= 16'h0000;
            type_reg    <= 8'h00;
            sync_ok_reg <= 1'b1;
            ver_ok_reg  <= 1'b1;
        end
        else
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            held0_reg   <= held0_next;
            held1_reg   <= held1_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            sync_ok_reg <= sync_ok_next;
            ver_ok_reg  <= ver_ok_next;
        end
    end

endmodule

FILE: design/frame_checker_crc16_core.sv
// frame_checker_crc16_core: top level of the CRC-16/MODBUS frame checker.
// Depends on fcc_pkg, fcc_cfg_regs and fcc_frame.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | in_data  (fcc_in_t: byte, last)
//  out     | output    | out_valid/out_stall| out_data (fcc_out_t: result item)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. An accepted item waits
// in the input register, then moves into the result register, where out_valid
// rises; a full, stalled result register holds it back. The unrolled 8-step CRC
// byte update plus the status compare set the path between the two registers.
// Reset (rst_n, async low) empties both registers and clears frame state.
// out_stall holds the result register; in_stall rises only when an item
// waits in the input register and the result register cannot move.
module frame_checker_crc16_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // item input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  fcc_pkg::fcc_in_t                in_data,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output fcc_pkg::fcc_out_t               out_data,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fcc_pkg::*;

    logic     in_valid_reg, in_valid_next;
    fcc_in_t  in_item_reg;
    logic     out_valid_reg, out_valid_next;
    fcc_out_t out_item_reg;
    fcc_out_t result;
    fcc_cfg_t cfg;
    logic     advance;   // result register can take a new item
    logic     fire;      // input-register item moves into the result register
    logic     take_in;   // item accepted on the input channel

    fcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    // input register refills whenever it is empty or moving on
    assign in_valid_next  = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= in_data;
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: design/fcc_checker.sv
// fcc_checker: port-level assertions for the frame checker, bound to the top.
// Depends on fcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input fcc_pkg::fcc_out_t out_data
);
    import fcc_pkg::*;

    `FCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `FCC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while output free")
    `FCC_ASSERT_NOW(a_mid_frame, out_valid && !out_data.frame_done, out_data.status == ST_OK && out_data.frame_type == 8'h00 && out_data.frame_len == 16'h0000, "report outside frame end")
    `FCC_ASSERT_NOW(a_fail_clear, out_valid && out_data.status != ST_OK, out_data.frame_type == 8'h00 && out_data.frame_len == 16'h0000, "fields shown on failed frame")
    `FCC_ASSERT_NOW(a_status_range, out_valid, out_data.status <= ST_BAD_CRC, "status code out of range")

endmodule

bind frame_checker_crc16_core fcc_checker u_fcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: sim/tb_top.sv
// tb_top: self-checking bench for frame_checker_crc16_core, the byte-serial CRC-16/MODBUS
// frame checker. It needs fcc_pkg and the RTL. A bit-exact frame predictor builds the
// expected results, which are checked against the result channel in order.
`timescale 1ns / 1ps

module tb_top;
    import fcc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 200;
    localparam int MAX_REPORTS  = 10;
    // Past the end of the register list, so the block must ignore a write to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'hFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    fcc_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    fcc_out_t               out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    frame_checker_crc16_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Items waiting to be offered, results still owed by the block, and the
    // staging area where a frame is assembled before release.
    fcc_in_t    pending_bytes[$];
    fcc_out_t   expected_results[$];
    logic [7:0] frame_bytes[$];

    int   items_queued = 0;
    int   fail_count = 0;
    int   result_count = 0;
    int   cycle_count = 0;
    int   idle_pct = 0;     // chance, in percent, of starting an idle burst
    logic long_hold = 1'b0; // receiver holds off while this is high
    int   send_gap;
    int   recv_gap;
    fcc_out_t want_result;

    // Register copies that the predictor works from.
    logic [7:0]  want_sync0;
    logic [7:0]  want_sync1;
    logic [7:0]  want_version;
    logic [15:0] limit_payload;

    // Per-frame state of the predictor.
    logic [CNT_W-1:0] frm_count;
    logic [15:0]      frm_crc;
    logic [7:0]       frm_held[2];
    logic [15:0]      frm_length;
    logic [7:0]       frm_type;
    logic             frm_sync_ok;
    logic             frm_version_ok;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // Bit-serial reflected CRC-16: feed the data bit into the LSB feedback.
    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                      input logic [7:0]  b);
        logic [15:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            acc = (acc >> 1) ^ ((acc[0] ^ b[i]) ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    function automatic void clear_frame();
        frm_count      = '0;
        frm_crc        = CRC_INIT;
        frm_held[0]    = 8'h00;
        frm_held[1]    = 8'h00;
        frm_length     = 16'h0000;
        frm_type       = 8'h00;
        frm_sync_ok    = 1'b1;
        frm_version_ok = 1'b1;
    endfunction

    // Advance the predictor by one accepted byte and return the result it owes.
    function automatic fcc_out_t predict_frame_byte(input fcc_in_t item);
        fcc_out_t         res;
        logic [CNT_W-1:0] pos;
        logic [7:0]       prev_byte;
        int unsigned      total;
        res       = '0;
        pos       = frm_count;
        prev_byte = frm_held[0];

        if (pos == POS_SYNC0 && item.data_byte != want_sync0)
            frm_sync_ok = 1'b0;
        if (pos == POS_SYNC1 && item.data_byte != want_sync1)
            frm_sync_ok = 1'b0;
        if (pos == POS_VERSION)
            frm_version_ok = (item.data_byte == want_version);
        if (pos == POS_TYPE)
            frm_type = item.data_byte;
        if (pos == POS_LEN_LO)
            frm_length[7:0] = item.data_byte;
        if (pos == POS_LEN_HI)
            frm_length[15:8] = item.data_byte;

        res.payload_byte  = item.data_byte;
        // Length as received so far; positions 4 and 5 are never payload anyway.
        res.payload_valid = (pos >= POS_PAYLOAD) && ((pos - POS_PAYLOAD) < frm_length);

        // The byte two back enters the CRC, so the trailing CRC bytes never do.
        if (pos >= POS_LEN_LO)
            frm_crc = crc16_modbus_step(frm_crc, frm_held[1]);
        frm_held[1] = frm_held[0];
        frm_held[0] = item.data_byte;
        if (frm_count != CNT_MAX)
            frm_count++;

        res.frame_done = item.last_byte;
        if (item.last_byte)
        begin
            total = pos + 1;
            if (total < MIN_FRAME)
                res.status = ST_SHORT;
            else if (!frm_sync_ok)
                res.status = ST_BAD_SYNC;
            else if (!frm_version_ok)
                res.status = ST_BAD_VERSION;
            else if (frm_length > limit_payload || total != 8 + frm_length)
                res.status = ST_BAD_LENGTH;
            else if ({item.data_byte, prev_byte} != frm_crc)
                res.status = ST_BAD_CRC;
            else
            begin
                res.status     = ST_OK;
                res.frame_type = frm_type;
                res.frame_len  = frm_length;
            end
            clear_frame();
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_frame_byte(in_data));

            if (in_valid && in_stall)
            begin
                // stalled: item stays put
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                in_data  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(1, 100) <= idle_pct)
                    send_gap = $urandom_range(1, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation
    // and drives random stall bursts plus the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d arrived with nothing expected: %p",
                                 result_count, out_data);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (out_data.payload_byte  !== want_result.payload_byte  ||
                        out_data.payload_valid !== want_result.payload_valid ||
                        out_data.frame_done    !== want_result.frame_done    ||
                        out_data.status        !== want_result.status        ||
                        out_data.frame_type    !== want_result.frame_type    ||
                        out_data.frame_len     !== want_result.frame_len)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result %0d mismatch: expected byte=%h pv=%b done=%b ",
                                      "status=%0d type=%h len=%h, got byte=%h pv=%b done=%b ",
                                      "status=%0d type=%h len=%h"},
                                     result_count,
                                     want_result.payload_byte, want_result.payload_valid,
                                     want_result.frame_done, want_result.status,
                                     want_result.frame_type, want_result.frame_len,
                                     out_data.payload_byte, out_data.payload_valid,
                                     out_data.frame_done, out_data.status,
                                     out_data.frame_type, out_data.frame_len);
                    end
                end
            end

            if (recv_gap > 0)
                recv_gap--;
            else if ($urandom_range(1, 100) <= idle_pct)
                recv_gap = $urandom_range(1, 13);
            out_stall <= long_hold || (recv_gap > 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Moves count staged bytes to the driver; the frame's final byte gets last set.
    task automatic release_bytes(input int count);
        fcc_in_t item;
        repeat (count)
        begin
            item.data_byte = frame_bytes.pop_front();
            item.last_byte = (frame_bytes.size() == 0);
            pending_bytes.push_back(item);
            items_queued++;
        end
    endtask

    // Stages a frame. crc_flip corrupts the CRC, adjust adds (>0) random bytes
    // at the end or drops (<0) bytes from it.
    task automatic build_frame(input logic [7:0] s0, s1, ver, ftype,
                               input logic [15:0] plen,
                               input logic [15:0] crc_flip,
                               input int adjust);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        frame_bytes.push_back(s0);
        frame_bytes.push_back(s1);
        frame_bytes.push_back(ver);
        frame_bytes.push_back(ftype);
        frame_bytes.push_back(plen[7:0]);
        frame_bytes.push_back(plen[15:8]);
        crc = crc16_modbus_step(crc, ver);
        crc = crc16_modbus_step(crc, ftype);
        crc = crc16_modbus_step(crc, plen[7:0]);
        crc = crc16_modbus_step(crc, plen[15:8]);
        for (int i = 0; i < int'(plen); i++)
        begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            crc = crc16_modbus_step(crc, b);
        end
        crc = crc ^ crc_flip;
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        for (int i = 0; i < adjust; i++)
            frame_bytes.push_back(8'($urandom));
        for (int i = 0; i < -adjust; i++)
            void'(frame_bytes.pop_back());
    endtask

    task automatic queue_frame(input logic [7:0] s0, s1, ver, ftype,
                               input logic [15:0] plen,
                               input logic [15:0] crc_flip,
                               input int adjust);
        build_frame(s0, s1, ver, ftype, plen, crc_flip, adjust);
        release_bytes(frame_bytes.size());
    endtask

    task automatic queue_raw_bytes(input int count);
        repeat (count)
            frame_bytes.push_back(8'($urandom));
        release_bytes(count);
    endtask

    // Mostly well-formed frames with random content; the rest hit each status
    // or are plain noise.
    task automatic queue_random_frame();
        int unsigned kind;
        int unsigned plen;
        int unsigned cap;
        int          adjust;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  ver;
        kind = $urandom_range(0, 99);
        cap  = (limit_payload < 24) ? limit_payload : 24;
        plen = $urandom_range(0, cap);
        if ($urandom_range(0, 19) == 0)
            plen = $urandom_range(0, (limit_payload < 300) ? limit_payload : 300);
        s0  = want_sync0;
        s1  = want_sync1;
        ver = want_version;

        if (kind < 58)
            queue_frame(s0, s1, ver, 8'($urandom), 16'(plen), 16'h0000, 0);
        else if (kind < 66)
            queue_frame(s0, s1, ver, 8'($urandom), 16'(plen),
                        16'(1 << $urandom_range(0, 15)), 0);
        else if (kind < 72)
        begin
            if ($urandom_range(0, 1) == 0)
                s0 = s0 ^ 8'($urandom_range(1, 255));
            else
                s1 = s1 ^ 8'($urandom_range(1, 255));
            queue_frame(s0, s1, ver, 8'($urandom), 16'(plen), 16'h0000, 0);
        end
        else if (kind < 77)
            queue_frame(s0, s1, ver ^ 8'($urandom_range(1, 255)), 8'($urandom),
                        16'(plen), 16'h0000, 0);
        else if (kind < 88)
        begin
            if (kind < 82 && limit_payload < 1000)
                // length field just over the limit, byte total consistent
                queue_frame(s0, s1, ver, 8'($urandom),
                            16'(limit_payload + $urandom_range(1, 3)), 16'h0000, 0);
            else
            begin
                // byte total disagrees with the length field
                adjust = (plen < 2) ? int'($urandom_range(1, 3)) : int'($urandom_range(0, 4)) - 2;
                if (adjust == 0)
                    adjust = 1;
                queue_frame(s0, s1, ver, 8'($urandom), 16'(plen), 16'h0000, adjust);
            end
        end
        else if (kind < 94)
            queue_raw_bytes($urandom_range(1, 7));
        else
            queue_raw_bytes($urandom_range(1, 24));
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0]  value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  want_sync0    = value[7:0];
            CFG_SYNC_SECOND: want_sync1    = value[7:0];
            CFG_VERSION:     want_version  = value[7:0];
            CFG_MAX_PAYLOAD: limit_payload = value;
            default: ;
        endcase
    endtask

    // Sampled mid-cycle so the driver and monitor have settled.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int random_base;
        want_sync0    = 8'h00;
        want_sync1    = 8'h00;
        want_version  = 8'h00;
        limit_payload = MAX_PAYLOAD_RST;
        clear_frame();
        idle_pct = 12;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, registers at reset values: good empty frame, one-byte
        // frame, bad second sync byte, bad version.
        queue_frame(8'h00, 8'h00, 8'h00, 8'hFF, 16'd0, 16'h0000, 0);
        frame_bytes.push_back(8'hFF);
        release_bytes(1);
        queue_frame(8'h00, 8'h80, 8'h00, 8'h00, 16'd0, 16'h0000, 0);
        queue_frame(8'h00, 8'h00, 8'hFF, 8'h00, 16'd0, 16'h0000, 0);
        wait_until_drained();

        // All-ones sync and version, no payload allowed; the unmapped index
        // must leave everything alone.
        write_register(CFG_SYNC_FIRST, 16'h00FF);
        write_register(CFG_SYNC_SECOND, 16'h00FF);
        write_register(CFG_VERSION, 16'h00FF);
        write_register(CFG_MAX_PAYLOAD, 16'h0000);
        write_register(CFG_UNMAPPED, 16'hFFFF);
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'h5A, 16'd0, 16'h0000, 0);   // ok
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'd1, 16'h0000, 0);   // over limit
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'd0, 16'h8000, 0);   // bad crc
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'd0, 16'h0000, 1);   // total off
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'd0, 16'h0000, -1);  // seven bytes
        wait_until_drained();

        // Random registers, random traffic with idling, then a calm stretch.
        write_register(CFG_SYNC_FIRST, 16'($urandom_range(0, 255)));
        write_register(CFG_SYNC_SECOND, 16'($urandom_range(0, 255)));
        write_register(CFG_VERSION, 16'($urandom_range(0, 255)));
        write_register(CFG_MAX_PAYLOAD, 16'($urandom_range(8, 64)));
        idle_pct    = 15;
        random_base = items_queued;
        while (items_queued - random_base < 350)
            queue_random_frame();
        wait_until_drained();
        idle_pct    = 0;
        random_base = items_queued;
        while (items_queued - random_base < 100)
            queue_random_frame();
        wait_until_drained();

        // Registers rewritten in the middle of a frame: the header already
        // checked must keep its verdict, the new limit applies at the end.
        idle_pct = 12;
        build_frame(want_sync0, want_sync1, want_version, 8'h3C, 16'd3, 16'h0000, 0);
        release_bytes(3);
        wait_until_drained();
        write_register(CFG_SYNC_FIRST, 16'(want_sync0 ^ 8'h5A));
        write_register(CFG_VERSION, 16'(want_version ^ 8'hA5));
        write_register(CFG_MAX_PAYLOAD, 16'd300);
        release_bytes(frame_bytes.size());

        // Heavy idling on both sides.
        idle_pct    = 30;
        random_base = items_queued;
        while (items_queued - random_base < 200)
            queue_random_frame();
        wait_until_drained();

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the block fills and stalls its input.
        idle_pct    = 0;
        random_base = items_queued;
        while (items_queued - random_base < 150)
            queue_random_frame();
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
        wait_until_drained();

        // Last part, no idling: widest limit and a longer good frame, then
        // more traffic.
        write_register(CFG_SYNC_FIRST, 16'h0000);
        write_register(CFG_SYNC_SECOND, 16'h0000);
        write_register(CFG_VERSION, 16'h0000);
        write_register(CFG_MAX_PAYLOAD, 16'hFFFF);
        queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 16'd40, 16'h0000, 0);
        random_base = items_queued;
        while (items_queued - random_base < 200)
            queue_random_frame();
        wait_until_drained();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/fcc_pkg.sv
design/fcc_cfg_regs.sv
design/fcc_frame.sv
design/frame_checker_crc16_core.sv
design/fcc_checker.sv
sim/tb_top.sv
